/* design/rpc_port_mapping_table_macros.svh */
// Assertion macros used by the port mapping table checker
`ifndef RPC_PORT_MAPPING_TABLE_MACROS_SVH
`define RPC_PORT_MAPPING_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is high
`define RPMT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define RPMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rpmt_pkg.sv */
// Package: types, codes and constants of the port mapping table
`timescale 1ns / 1ps
package rpmt_pkg;

  localparam int CAPACITY_DEF = 64;

  // Register reset values and limits
  localparam logic [6:0]  MAX_ENTRIES_RST = 7'd64;
  localparam logic [31:0] TIMEOUT_RST     = 32'd3600;
  localparam logic        CLEANUP_EN_RST  = 1'b1;
  localparam logic [31:0] PROTO_TCP       = 32'd6;
  localparam logic [31:0] PROTO_UDP       = 32'd17;
  localparam logic [6:0]  REMOVED_MAX     = 7'd127;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_CLEANUP_EN  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_REGISTER  = 3'd0,
    OP_UNREG     = 3'd1,
    OP_UNREG_ALL = 3'd2,
    OP_LOOKUP    = 3'd3,
    OP_TICK      = 3'd4,
    OP_CLEANUP   = 3'd5
  } op_t;

  // One table row
  typedef struct packed {
    logic        valid;
    logic [30:0] prog;
    logic [30:0] ver;
    logic        is_udp;
    logic [15:0] port;
    logic [31:0] stamp;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_last;
    logic needs_scan;
    logic out_free;
  } dp_stat_t;

  // Program and version numbers run 1..0x7FFFFFFF
  function automatic logic id_ok(input logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

  function automatic logic proto_ok(input logic [31:0] p);
    return (p == PROTO_TCP) || (p == PROTO_UDP);
  endfunction

endpackage

/* design/rpmt_ctrl.sv */
// Controller: clearing pass, table scan sequencing and result commit
`timescale 1ns / 1ps
module rpmt_ctrl import rpmt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = st.needs_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.idx_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.commit = st.out_free;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* design/rpmt_datapath.sv */
// Datapath: table memory, scan compare stage, counters and result register
`timescale 1ns / 1ps
module rpmt_datapath import rpmt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    st,
  input  logic [2:0]  op,
  input  logic [31:0] program_req,
  input  logic [31:0] version,
  input  logic [31:0] protocol,
  input  logic [31:0] port_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] port_out,
  output logic [6:0]  removed_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);

  // Configuration
  logic [6:0]  max_entries;
  logic [31:0] entry_timeout;
  logic        cleanup_enable;

  // Table and scan pipeline
  row_t          mem [CAPACITY];
  row_t          rd_row;
  logic [IW-1:0] idx;
  logic [IW-1:0] cmp_idx;
  logic          cmp_vld;

  // Latched request
  logic [2:0]  req_op;
  logic [31:0] req_prog;
  logic [31:0] req_ver;
  logic        req_udp;
  logic [15:0] req_port;
  logic        req_scan;
  logic        req_reg_ok;

  // Scan results and block state
  logic [31:0]   now_seconds;
  logic [CW-1:0] live;
  logic [CW-1:0] live_next;
  logic [CW-1:0] removed;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [15:0]   hit_port;
  logic          free_found;
  logic [IW-1:0] free_idx;

  // Write port
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  row_t          mem_wdata;

  // Combinational decisions
  logic          in_key_ok;
  logic          in_reg_ok;
  logic [LW-1:0] limit;
  logic          has_room;
  logic          needs_scan;
  logic          prog_eq;
  logic          ver_eq;
  logic          key_eq;
  logic [31:0]   age;
  logic          drop;
  logic [LW-1:0] removed_ext;
  logic [6:0]    removed_sat;
  logic [1:0]    res_status;
  logic [15:0]   res_port;
  logic [6:0]    res_removed;
  logic          commit_write;
  logic          add_entry;

  // Check the incoming beat and decide whether it needs a scan
  always_comb begin
    in_key_ok = id_ok(program_req) && id_ok(version) && proto_ok(protocol);
    in_reg_ok = in_key_ok && (port_in != 32'd0) && (port_in[31:16] == 16'd0);
    limit     = (LW'(max_entries) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_entries);
    has_room  = LW'(live) < limit;
    case (op)
      OP_REGISTER:  needs_scan = in_reg_ok && has_room;
      OP_UNREG:     needs_scan = in_key_ok;
      OP_UNREG_ALL: needs_scan = 1'b1;
      OP_LOOKUP:    needs_scan = in_key_ok;
      OP_CLEANUP:   needs_scan = cleanup_enable;
      default:      needs_scan = 1'b0;
    endcase
  end

  assign st.idx_last   = (idx == IDX_LAST);
  assign st.needs_scan = needs_scan;
  assign st.out_free   = !out_valid || out_ready;

  // Compare stage on the row read in the previous cycle
  always_comb begin
    prog_eq = ({1'b0, rd_row.prog} == req_prog);
    ver_eq  = ({1'b0, rd_row.ver} == req_ver);
    key_eq  = rd_row.valid && prog_eq && ver_eq && (rd_row.is_udp == req_udp);
    age     = now_seconds - rd_row.stamp;
    drop    = 1'b0;
    if (cmp_vld) begin
      case (req_op)
        OP_UNREG:     drop = key_eq;
        OP_UNREG_ALL: drop = rd_row.valid && prog_eq && ver_eq;
        OP_CLEANUP:   drop = rd_row.valid && (age > entry_timeout);
        default:      drop = 1'b0;
      endcase
    end
  end

  // Build the result of the finished operation
  always_comb begin
    removed_ext  = LW'(removed);
    removed_sat  = (removed_ext > LW'(REMOVED_MAX)) ? REMOVED_MAX : removed_ext[6:0];
    res_status   = ST_OK;
    res_port     = 16'd0;
    res_removed  = 7'd0;
    commit_write = 1'b0;
    add_entry    = 1'b0;
    case (req_op)
      OP_REGISTER: begin
        if (!req_reg_ok) begin
          res_status = ST_INVALID;
        end else if (!req_scan) begin
          res_status = ST_FULL;
        end else if (hit) begin
          commit_write = 1'b1;
        end else if (free_found) begin
          commit_write = 1'b1;
          add_entry    = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_UNREG, OP_UNREG_ALL: begin
        res_status  = (removed != '0) ? ST_OK : ST_NOT_FOUND;
        res_removed = removed_sat;
      end
      OP_LOOKUP: begin
        res_status = hit ? ST_OK : ST_NOT_FOUND;
        res_port   = hit ? hit_port : 16'd0;
      end
      OP_TICK: begin
        res_status = ST_OK;
      end
      OP_CLEANUP: begin
        res_removed = removed_sat;
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  // Select the single write into the table
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx;
    mem_wdata = rd_row;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (drop) begin
      mem_we          = 1'b1;
      mem_addr        = cmp_idx;
      mem_wdata.valid = 1'b0;
    end else if (cmd.commit && commit_write) begin
      mem_we           = 1'b1;
      mem_addr         = hit ? hit_idx : free_idx;
      mem_wdata.valid  = 1'b1;
      mem_wdata.prog   = req_prog[30:0];
      mem_wdata.ver    = req_ver[30:0];
      mem_wdata.is_udp = req_udp;
      mem_wdata.port   = req_port;
      mem_wdata.stamp  = now_seconds;
    end
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_row <= mem[idx];
  end

  // Live count: drop on removal, bump on a new entry
  always_comb begin
    live_next = live;
    if (drop && (live != '0)) begin
      live_next = live - CW'(1);
    end else if (cmd.commit && add_entry) begin
      live_next = live + CW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries    <= MAX_ENTRIES_RST;
      entry_timeout  <= TIMEOUT_RST;
      cleanup_enable <= CLEANUP_EN_RST;
      idx            <= '0;
      cmp_vld        <= 1'b0;
      now_seconds    <= '0;
      live           <= '0;
      removed        <= '0;
      hit            <= 1'b0;
      free_found     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ENTRIES: max_entries    <= cfg_data[6:0];
          REG_TIMEOUT:     entry_timeout  <= cfg_data;
          REG_CLEANUP_EN:  cleanup_enable <= cfg_data[0];
          default:         ;
        endcase
      end
      if (cmd.accept) begin
        idx <= '0;
      end else if (cmd.clear || cmd.scan) begin
        idx <= (idx == IDX_LAST) ? '0 : idx + IW'(1);
      end
      cmp_vld <= cmd.scan;
      live    <= live_next;
      if (cmd.accept) begin
        removed    <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (cmp_vld) begin
        if (drop) begin
          removed <= removed + CW'(1);
        end
        if (key_eq && !hit) begin
          hit <= 1'b1;
        end
        if (!rd_row.valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.commit && (req_op == OP_TICK)) begin
        now_seconds <= now_seconds + 32'd1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op     <= op;
      req_prog   <= program_req;
      req_ver    <= version;
      req_udp    <= (protocol == PROTO_UDP);
      req_port   <= port_in[15:0];
      req_scan   <= needs_scan;
      req_reg_ok <= in_reg_ok;
    end
    cmp_idx <= idx;
    if (cmp_vld && key_eq && !hit) begin
      hit_idx  <= cmp_idx;
      hit_port <= rd_row.port;
    end
    if (cmp_vld && !rd_row.valid && !free_found) begin
      free_idx <= cmp_idx;
    end
    if (cmd.commit) begin
      status        <= res_status;
      port_out      <= res_port;
      removed_count <= res_removed;
    end
  end

endmodule

/* design/rpc_port_mapping_table.sv */
// Top level of the RPC port mapping table
`timescale 1ns / 1ps
// Maps (program, version, protocol) to a port in a table of CAPACITY rows held
// in one single-port-write, registered-read memory. After reset the block runs
// a clearing pass over all CAPACITY rows, with in_ready low, before it takes a
// beat. Register, unregister, unregister_all, lookup and cleanup while enabled
// sweep the whole table one row a cycle through that memory port. Tick, unknown
// ops, cleanup while disabled, unregister and lookup with a key that could never
// be registered, and registers refused on their fields or on a full table skip
// the sweep. One request is in flight at a time; a finished result sits in the
// output register, and the next request is accepted while it waits, but its
// own result is held back until that register is free. Configuration writes
// are taken at any time but belong in idle periods.
module rpc_port_mapping_table import rpmt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [31:0] program_req,
  input  logic [31:0] version,
  input  logic [31:0] protocol,
  input  logic [31:0] port_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] port_out,
  output logic [6:0]  removed_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t st;

  // Sequence the operation
  rpmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold the table and build results
  rpmt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .op            (op),
    .program_req   (program_req),
    .version       (version),
    .protocol      (protocol),
    .port_in       (port_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .port_out      (port_out),
    .removed_count (removed_count),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

endmodule

/* design/rpmt_checker.sv */
// Port-level checker for the port mapping table, bound to the top level
`timescale 1ns / 1ps
`include "rpc_port_mapping_table_macros.svh"
module rpmt_checker import rpmt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] port_out,
  input logic [6:0]  removed_count
);

  // Hold a stalled result beat
  `RPMT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(port_out) && $stable(removed_count),
    "result beat changed while stalled")

  // Take one request at a time
  `RPMT_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready,
    "second request taken while one is in flight")

  // A found port only comes with an ok status
  `RPMT_ASSERT_IMP(a_port_ok, clk, rst, out_valid && (port_out != 16'd0),
    status == ST_OK, "port returned with a failing status")

  // Removals only come with an ok status
  `RPMT_ASSERT_IMP(a_removed_ok, clk, rst, out_valid && (removed_count != 7'd0),
    status == ST_OK, "removal count with a failing status")

endmodule

bind rpc_port_mapping_table rpmt_checker u_rpmt_checker (.*);

/* tb/sv/rpc_port_mapping_table_tb.sv */
// Testbench for the RPC port mapping table: directed and random beats with a scoreboard
`timescale 1ns / 1ps
module rpc_port_mapping_table_tb;
  import rpmt_pkg::*;

  localparam int          SLOTS      = CAPACITY_DEF;
  localparam int          LIMIT      = 1000000;
  localparam int          PHASE_LEN  = 400;
  localparam logic [31:0] ID_TOP     = 32'h7FFF_FFFF;
  localparam logic [31:0] PORT_TOP   = 32'd65535;
  localparam logic [2:0]  OP_UNDEF_A = 3'd6;
  localparam logic [2:0]  OP_UNDEF_B = 3'd7;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] port;
    logic [6:0]  removed;
  } reply_t;

  // Tracks the bindings the block should hold and the replies it owes
  class binding_tracker;
    logic        live_tab  [SLOTS];
    logic [30:0] prog_tab  [SLOTS];
    logic [30:0] ver_tab   [SLOTS];
    logic        udp_tab   [SLOTS];
    logic [15:0] port_tab  [SLOTS];
    logic [31:0] stamp_tab [SLOTS];
    logic [31:0] clock_secs;
    int          live;
    logic [6:0]  max_entries;
    logic [31:0] timeout;
    logic        cleanup_en;
    reply_t      pending_replies[$];
    int          mismatches;

    function new();
      foreach (live_tab[i]) live_tab[i] = 1'b0;
      clock_secs  = '0;
      live        = 0;
      max_entries = MAX_ENTRIES_RST;
      timeout     = TIMEOUT_RST;
      cleanup_en  = CLEANUP_EN_RST;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MAX_ENTRIES: max_entries = val[6:0];
        REG_TIMEOUT:     timeout     = val;
        REG_CLEANUP_EN:  cleanup_en  = val[0];
        default: ;
      endcase
    endfunction

    // Slot of a live matching key, or -1; keys that could never be bound find nothing
    function int find_slot(logic [31:0] prg, logic [31:0] ver, logic [31:0] proto);
      if (prg == 0 || prg > ID_TOP || ver == 0 || ver > ID_TOP ||
          !(proto == PROTO_TCP || proto == PROTO_UDP))
        return -1;
      for (int i = 0; i < SLOTS; i++)
        if (live_tab[i] && {1'b0, prog_tab[i]} == prg && {1'b0, ver_tab[i]} == ver &&
            udp_tab[i] == (proto == PROTO_UDP))
          return i;
      return -1;
    endfunction

    function void drop(int i);
      live_tab[i] = 1'b0;
      if (live > 0) live--;
    endfunction

    // Work out the reply owed for one accepted request beat
    function void note_request(logic [2:0] opc, logic [31:0] prg, logic [31:0] ver,
                               logic [31:0] proto, logic [31:0] prt);
      reply_t      r;
      int          slot;
      int          lim;
      int          n;
      logic [31:0] age;
      r.status  = ST_OK;
      r.port    = '0;
      r.removed = '0;
      n   = 0;
      lim = (int'(max_entries) > SLOTS) ? SLOTS : int'(max_entries);
      case (opc)
        OP_REGISTER: begin
          if (prg == 0 || prg > ID_TOP || ver == 0 || ver > ID_TOP ||
              !(proto == PROTO_TCP || proto == PROTO_UDP) || prt == 0 || prt > PORT_TOP) begin
            r.status = ST_INVALID;
          end else if (live >= lim) begin
            // full even when the key is already bound
            r.status = ST_FULL;
          end else begin
            slot = find_slot(prg, ver, proto);
            if (slot < 0) begin
              for (int i = 0; i < SLOTS; i++)
                if (!live_tab[i] && slot < 0) slot = i;
              if (slot < 0) begin
                r.status = ST_FULL;
              end else begin
                live_tab[slot] = 1'b1;
                prog_tab[slot] = prg[30:0];
                ver_tab[slot]  = ver[30:0];
                udp_tab[slot]  = (proto == PROTO_UDP);
                live++;
              end
            end
            if (r.status == ST_OK) begin
              port_tab[slot]  = prt[15:0];
              stamp_tab[slot] = clock_secs;
            end
          end
        end
        OP_UNREG: begin
          slot = find_slot(prg, ver, proto);
          if (slot < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            drop(slot);
            n = 1;
          end
        end
        OP_UNREG_ALL: begin
          for (int i = 0; i < SLOTS; i++)
            if (live_tab[i] && {1'b0, prog_tab[i]} == prg && {1'b0, ver_tab[i]} == ver) begin
              drop(i);
              n++;
            end
          if (n == 0) r.status = ST_NOT_FOUND;
        end
        OP_LOOKUP: begin
          slot = find_slot(prg, ver, proto);
          if (slot < 0) r.status = ST_NOT_FOUND;
          else r.port = port_tab[slot];
        end
        OP_TICK: clock_secs = clock_secs + 32'd1;
        OP_CLEANUP: begin
          if (cleanup_en)
            for (int i = 0; i < SLOTS; i++) begin
              age = clock_secs - stamp_tab[i];
              if (live_tab[i] && age > timeout) begin
                drop(i);
                n++;
              end
            end
        end
        default: r.status = ST_INVALID;
      endcase
      r.removed = (n > 127) ? REMOVED_MAX : n[6:0];
      pending_replies.insert(pending_replies.size(), r);
    endfunction

    // Compare one reply beat with the oldest owed reply
    function void check_reply(logic [1:0] st, logic [15:0] prt, logic [6:0] rem);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual status %0d port %0d removed %0d",
                 $time, st, prt, rem);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status) begin
        $display("%0t: status: expected %0d, actual %0d", $time, e.status, st);
        mismatches++;
      end
      if (prt !== e.port) begin
        $display("%0t: port_out: expected %0d, actual %0d", $time, e.port, prt);
        mismatches++;
      end
      if (rem !== e.removed) begin
        $display("%0t: removed_count: expected %0d, actual %0d", $time, e.removed, rem);
        mismatches++;
      end
    endfunction

    function int owed();
      return pending_replies.size();
    endfunction
  endclass

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [2:0]  op          = '0;
  logic [31:0] program_req = '0;
  logic [31:0] version     = '0;
  logic [31:0] protocol    = '0;
  logic [31:0] port_in     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [1:0]  status;
  logic [15:0] port_out;
  logic [6:0]  removed_count;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [31:0] cfg_data    = '0;

  binding_tracker tracker = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int cycles         = 0;

  rpc_port_mapping_table dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Note request beats and check reply beats
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      tracker.note_request(op, program_req, version, protocol, port_in);
    if (!rst && out_valid && out_ready)
      tracker.check_reply(status, port_out, removed_count);
  end

  // Offer one request beat, idling first at random, and wait for it to be taken
  task automatic offer(logic [2:0] o, logic [31:0] prg, logic [31:0] ver,
                       logic [31:0] proto, logic [31:0] prt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    program_req <= prg;
    version     <= ver;
    protocol    <= proto;
    port_in     <= prt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, let the last beat be noted, and wait until every owed reply has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    tracker.write_reg(idx, val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random request: mostly keys from a small pool so that they collide, some noise
  task automatic random_beat(int reg_pct);
    logic [2:0]  o;
    logic [31:0] prg;
    logic [31:0] ver;
    logic [31:0] proto;
    logic [31:0] prt;
    int          w;
    if ($urandom_range(99) < 8) begin
      offer(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
      return;
    end
    if ($urandom_range(99) < reg_pct) begin
      o = OP_REGISTER;
    end else begin
      w = $urandom_range(99);
      if (w < 35)      o = OP_LOOKUP;
      else if (w < 55) o = OP_UNREG;
      else if (w < 67) o = OP_UNREG_ALL;
      else if (w < 87) o = OP_TICK;
      else             o = OP_CLEANUP;
    end
    prg   = ($urandom_range(9) == 0) ? ID_TOP : $urandom_range(1, 12);
    ver   = ($urandom_range(9) == 0) ? ID_TOP : $urandom_range(1, 3);
    proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    if ($urandom_range(19) == 0) proto = $urandom_range(0, 31);
    w = $urandom_range(19);
    if (w == 0)      prt = PORT_TOP;
    else if (w == 1) prt = 32'd1;
    else if (w == 2) prt = $urandom_range(0, 70000);
    else             prt = $urandom_range(1, 65535);
    offer(o, prg, ver, proto, prt);
  endtask

  initial begin
    int        ph;
    int        k;
    logic [6:0]  ph_max   [4];
    logic [31:0] ph_tmo   [4];
    logic        ph_clean [4];
    int          ph_send  [4];
    int          ph_recv  [4];
    int          ph_reg   [4];
    ph_max   = '{7'd127, 7'd3, 7'd64, 7'd16};
    ph_tmo   = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd2};
    ph_clean = '{1'b1, 1'b1, 1'b1, 1'b0};
    ph_send  = '{0, 74, 0, 25};
    ph_recv  = '{0, 0, 74, 25};
    ph_reg   = '{40, 40, 65, 45};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: bind, overwrite, field checks, lookups, removals, unknown ops
    offer(OP_REGISTER, 32'd1, 32'd1, PROTO_TCP, 32'd111);
    offer(OP_REGISTER, ID_TOP, ID_TOP, PROTO_UDP, PORT_TOP);
    offer(OP_REGISTER, 32'd1, 32'd1, PROTO_TCP, 32'd1);
    offer(OP_REGISTER, 32'd0, 32'd1, PROTO_TCP, 32'd5);
    offer(OP_REGISTER, 32'h8000_0000, 32'd1, PROTO_TCP, 32'd5);
    offer(OP_REGISTER, 32'd1, 32'd0, PROTO_TCP, 32'd5);
    offer(OP_REGISTER, 32'd1, 32'd1, 32'd7, 32'd5);
    offer(OP_REGISTER, 32'd1, 32'd1, PROTO_UDP, 32'd0);
    offer(OP_REGISTER, 32'd1, 32'd1, PROTO_UDP, 32'd65536);
    offer(OP_LOOKUP, 32'd1, 32'd1, PROTO_TCP, 32'd0);
    offer(OP_LOOKUP, 32'd1, 32'd1, PROTO_UDP, 32'd0);
    offer(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(OP_REGISTER, 32'd1, 32'd1, PROTO_UDP, 32'd2);
    offer(OP_UNREG_ALL, 32'd1, 32'd1, 32'd0, 32'd0);
    offer(OP_UNREG_ALL, 32'd1, 32'd1, 32'd0, 32'd0);
    offer(OP_UNREG, ID_TOP, ID_TOP, PROTO_UDP, 32'd0);
    offer(OP_UNREG, ID_TOP, ID_TOP, PROTO_UDP, 32'd0);
    offer(OP_UNDEF_A, 32'd1, 32'd1, PROTO_TCP, 32'd9);
    offer(OP_UNDEF_B, 32'd1, 32'd1, PROTO_TCP, 32'd9);
    offer(OP_TICK, 32'd0, 32'd0, 32'd0, 32'd0);
    offer(OP_CLEANUP, 32'd0, 32'd0, 32'd0, 32'd0);
    drain();

    // Directed: full table with the key present, expiry, cleanup disabled, zero limit
    cfg_write(REG_MAX_ENTRIES, 32'd1);
    cfg_write(REG_TIMEOUT, 32'd0);
    offer(OP_REGISTER, 32'd2, 32'd2, PROTO_TCP, 32'd22);
    offer(OP_REGISTER, 32'd3, 32'd3, PROTO_TCP, 32'd33);
    offer(OP_REGISTER, 32'd2, 32'd2, PROTO_TCP, 32'd44);
    offer(OP_TICK, 32'd0, 32'd0, 32'd0, 32'd0);
    offer(OP_CLEANUP, 32'd0, 32'd0, 32'd0, 32'd0);
    drain();
    cfg_write(REG_CLEANUP_EN, 32'd0);
    offer(OP_REGISTER, 32'd2, 32'd2, PROTO_UDP, 32'd22);
    offer(OP_TICK, 32'd0, 32'd0, 32'd0, 32'd0);
    offer(OP_CLEANUP, 32'd0, 32'd0, 32'd0, 32'd0);
    drain();
    cfg_write(REG_MAX_ENTRIES, 32'd0);
    offer(OP_REGISTER, 32'd4, 32'd4, PROTO_TCP, 32'd44);
    drain();

    // Random phases, each with its own settings and idling
    for (ph = 0; ph < 4; ph++) begin
      cfg_write(REG_MAX_ENTRIES, ph_max[ph]);
      cfg_write(REG_TIMEOUT, ph_tmo[ph]);
      cfg_write(REG_CLEANUP_EN, ph_clean[ph]);
      send_idle_pct  = ph_send[ph];
      recv_stall_pct = ph_recv[ph];
      for (k = 0; k < PHASE_LEN; k++) begin
        // hold the reply side off so the block backs up into its input
        if (ph == 0 && k == 100) hold_req = 300;
        random_beat(ph_reg[ph]);
      end
      drain();
    end

    repeat (80) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
